@@ sv/caching_lock_manager_top_defines.svh @@
// Assertion macros used by the checker file of the lock manager.
`ifndef CACHING_LOCK_MANAGER_TOP_DEFINES_SVH
`define CACHING_LOCK_MANAGER_TOP_DEFINES_SVH

// An implication that is checked at every rising edge outside reset.
`define CLM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must never be seen at a rising edge outside reset.
`define CLM_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/clm_pkg.sv @@
`default_nettype none

package clm_pkg;

    // Table size and field widths.
    localparam int LOCKS    = 256;
    localparam int CLIENTS  = 16;
    localparam int LOCK_W   = $clog2(LOCKS);
    localparam int CLIENT_W = $clog2(CLIENTS);

    // Lock phases.
    localparam logic [1:0] PH_FREE   = 2'd0;
    localparam logic [1:0] PH_LOCKED = 2'd1;
    localparam logic [1:0] PH_WAIT   = 2'd2;
    localparam logic [1:0] PH_RETRY  = 2'd3;

    // Request modes.
    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Reply status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RETRY = 1'b1;

    // Message kinds.
    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_REVOKE = 2'd1;
    localparam logic [1:0] MSG_RETRY  = 2'd2;

    // One request item.
    typedef struct packed {
        logic                mode;
        logic [LOCK_W-1:0]   lock_id;
        logic [CLIENT_W-1:0] client_id;
    } req_t;

    // One result item.
    typedef struct packed {
        logic                reply_status;
        logic [1:0]          message_kind;
        logic [CLIENT_W-1:0] message_client;
        logic [LOCK_W-1:0]   message_lock;
    } rsp_t;

    // One lock table entry.
    typedef struct packed {
        logic [1:0]          phase;
        logic [CLIENT_W-1:0] holder;
        logic [CLIENTS-1:0]  waiter_mask;
        logic [CLIENT_W-1:0] retry_target;
    } entry_t;

    // Write port of the lock table.
    typedef struct packed {
        logic              en;
        logic [LOCK_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

endpackage

`default_nettype wire

@@ sv/clm_table.sv @@
`default_nettype none

module clm_table
    import clm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [LOCK_W-1:0] rd_addr,
    input  wire tbl_wr_t           wr,
    output entry_t                 entry
);

    entry_t            mem [LOCKS];
    entry_t            rd_data_reg;
    entry_t            fwd_data_reg;
    logic [LOCKS-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic              fwd_hit_reg;

    // Table storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    // Per-entry written flags; an unwritten entry reads as a free lock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                fwd_hit_reg  <= wr.en && (wr.addr == rd_addr);
            end
        end
    end

    // A write to the same entry in the read cycle wins over the stale array data.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            entry = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            entry = rd_data_reg;
        end
        else
        begin
            entry = '0;
        end
    end

endmodule

`default_nettype wire

@@ sv/clm_engine.sv @@
`default_nettype none

module clm_engine
    import clm_pkg::*;
(
    input  wire req_t   req,
    input  wire entry_t entry,
    output entry_t      nxt,
    output rsp_t        rsp
);

    // Index of the lowest set bit of a waiter mask.
    function automatic logic [CLIENT_W-1:0] lowest_waiter(input logic [CLIENTS-1:0] mask);
        logic [CLIENT_W-1:0] idx;
        idx = '0;
        for (int i = CLIENTS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = CLIENT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [CLIENTS-1:0]  client_bit;
    logic [CLIENTS-1:0]  mask_without;
    logic [CLIENT_W-1:0] first_waiter;

    assign client_bit   = CLIENTS'(1) << req.client_id;
    assign mask_without = entry.waiter_mask & ~client_bit;
    assign first_waiter = lowest_waiter(entry.waiter_mask);

    // Next entry and reply for one request.
    always_comb
    begin
        nxt                 = entry;
        rsp.reply_status    = STATUS_OK;
        rsp.message_kind    = MSG_NONE;
        rsp.message_client  = '0;
        rsp.message_lock    = '0;

        if (req.mode == MODE_ACQUIRE)
        begin
            case (entry.phase)
                PH_FREE:
                begin
                    nxt.holder = req.client_id;
                    nxt.phase  = PH_LOCKED;
                end
                PH_LOCKED:
                begin
                    nxt.waiter_mask    = entry.waiter_mask | client_bit;
                    nxt.phase          = PH_WAIT;
                    rsp.reply_status   = STATUS_RETRY;
                    rsp.message_kind   = MSG_REVOKE;
                    rsp.message_client = entry.holder;
                    rsp.message_lock   = req.lock_id;
                end
                PH_WAIT:
                begin
                    nxt.waiter_mask  = entry.waiter_mask | client_bit;
                    rsp.reply_status = STATUS_RETRY;
                end
                default:
                begin
                    // Retrying: only the retry target may take the lock.
                    if (req.client_id == entry.retry_target)
                    begin
                        nxt.waiter_mask  = mask_without;
                        nxt.holder       = req.client_id;
                        nxt.retry_target = '0;
                        if (mask_without == '0)
                        begin
                            nxt.phase = PH_LOCKED;
                        end
                        else
                        begin
                            nxt.phase          = PH_WAIT;
                            rsp.message_kind   = MSG_REVOKE;
                            rsp.message_client = req.client_id;
                            rsp.message_lock   = req.lock_id;
                        end
                    end
                    else
                    begin
                        nxt.waiter_mask  = entry.waiter_mask | client_bit;
                        rsp.reply_status = STATUS_RETRY;
                    end
                end
            endcase
        end
        else
        begin
            case (entry.phase)
                PH_LOCKED:
                begin
                    nxt.phase  = PH_FREE;
                    nxt.holder = '0;
                end
                PH_WAIT:
                begin
                    // An empty waiter set simply frees the lock.
                    if (entry.waiter_mask == '0)
                    begin
                        nxt.phase  = PH_FREE;
                        nxt.holder = '0;
                    end
                    else
                    begin
                        nxt.phase          = PH_RETRY;
                        nxt.retry_target   = first_waiter;
                        rsp.message_kind   = MSG_RETRY;
                        rsp.message_client = first_waiter;
                        rsp.message_lock   = req.lock_id;
                    end
                end
                default:
                begin
                    // Free or retrying: the release changes nothing.
                    nxt = entry;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/caching_lock_manager_top.sv @@
// Channel   | Ports                  | Handshake
// ----------+------------------------+---------------------------------------
// request   | start, busy, request   | taken at an edge with start high, busy low
// result    | result_valid, result   | valid for a single cycle per item, no back-pressure
//
// One item per clock cycle. An item moves from the update stage register to the result register,
// which drives the result ports.
// The rate is set by the lock table: one read at acceptance, one write in the following cycle.
// A request to the lock being written in its read cycle is served by forwarding.
// Reset clears the written flags of all 256 entries at once, so no clearing pass runs.
// busy stays low; the result side cannot stall and is never waited on.
`default_nettype none

module caching_lock_manager_top
    import clm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output logic      result_valid,
    output rsp_t      result
);

    logic    accept;
    logic    s1_valid_reg;
    req_t    s1_req_reg;
    logic    result_valid_reg;
    rsp_t    result_reg;
    entry_t  entry;
    entry_t  nxt;
    rsp_t    rsp;
    tbl_wr_t wr;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Lock table: read at acceptance, written back from the update stage.
    clm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (request.lock_id),
        .wr      (wr),
        .entry   (entry)
    );

    // Phase update and reply for the item in the update stage.
    clm_engine u_engine (
        .req   (s1_req_reg),
        .entry (entry),
        .nxt   (nxt),
        .rsp   (rsp)
    );

    assign wr.en   = s1_valid_reg;
    assign wr.addr = s1_req_reg.lock_id;
    assign wr.data = nxt;

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= accept;
            result_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= request;
        end
        if (s1_valid_reg)
        begin
            result_reg <= rsp;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

@@ sv/clm_checker.sv @@
`default_nettype none
`include "caching_lock_manager_top_defines.svh"

module clm_checker
    import clm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire req_t request,
    input wire logic result_valid,
    input wire rsp_t result
);

    // Every result answers an item taken at the request port.
    `CLM_ASSERT_IMP(a_result_has_item,
        result_valid, $past(start && !busy, 2), "result without item")

    // A release is always answered OK.
    `CLM_ASSERT_IMP(a_release_ok,
        result_valid && ($past(request.mode, 2) == MODE_RELEASE),
        result.reply_status == STATUS_OK, "release not OK")

    // A retry message only follows a release; a revoke only follows an acquire.
    `CLM_ASSERT_IMP(a_retry_from_release,
        result_valid && (result.message_kind == MSG_RETRY),
        $past(request.mode, 2) == MODE_RELEASE, "retry message on acquire")

    // The message lock matches the lock named by the item.
    `CLM_ASSERT_IMP(a_message_lock,
        result_valid && (result.message_kind != MSG_NONE),
        result.message_lock == $past(request.lock_id, 2), "message names wrong lock")

    // The unused message code never appears.
    `CLM_ASSERT_NEVER(a_kind_code,
        result_valid && (result.message_kind > MSG_RETRY), "bad message kind")

endmodule

bind caching_lock_manager_top clm_checker u_clm_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import clm_pkg::*;

    localparam logic [LOCK_W-1:0]   TOP_LOCK   = LOCK_W'(LOCKS - 1);
    localparam logic [CLIENT_W-1:0] TOP_CLIENT = CLIENT_W'(CLIENTS - 1);
    localparam int RANDOM_ITEMS = 500;

    // One queued request together with its pacing flags.
    typedef struct {
        req_t req;
        bit   hold;
        bit   calm;
    } pending_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic result_valid;
    rsp_t result;

    pending_item_t pending[$];
    rsp_t awaited_replies[$];
    int accepted_count = 0;
    int received_count = 0;
    int mismatch_count = 0;

    // Stimulus bookkeeping.
    bit directed_phase = 1'b1;
    int random_items = 0;
    bit touched [LOCKS];
    logic [LOCK_W-1:0] touched_locks[$];

    // Predicted lock table.
    logic [1:0]          lock_state [LOCKS];
    logic [CLIENT_W-1:0] lock_owner [LOCKS];
    logic [CLIENTS-1:0]  lock_waiters [LOCKS];
    logic [CLIENT_W-1:0] lock_retry_client [LOCKS];

    caching_lock_manager_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CLIENT_W-1:0] any_client();
        return CLIENT_W'($urandom_range(CLIENTS - 1));
    endfunction

    function automatic logic [LOCK_W-1:0] any_lock();
        return LOCK_W'($urandom_range(LOCKS - 1));
    endfunction

    // Applies one request to the predicted lock table and returns the expected reply.
    function automatic rsp_t serve_request(req_t r);
        rsp_t rsp;
        logic [CLIENTS-1:0] client_bit;
        logic [CLIENT_W-1:0] lowest;
        rsp = '0;
        rsp.reply_status = STATUS_OK;
        rsp.message_kind = MSG_NONE;
        client_bit = '0;
        client_bit[r.client_id] = 1'b1;
        lowest = '0;
        if (r.mode == MODE_ACQUIRE)
        begin
            case (lock_state[r.lock_id])
                PH_FREE:
                begin
                    lock_owner[r.lock_id] = r.client_id;
                    lock_state[r.lock_id] = PH_LOCKED;
                end
                PH_LOCKED:
                begin
                    // The first contender makes the holder give the lock back.
                    lock_waiters[r.lock_id] = lock_waiters[r.lock_id] | client_bit;
                    lock_state[r.lock_id] = PH_WAIT;
                    rsp.reply_status = STATUS_RETRY;
                    rsp.message_kind = MSG_REVOKE;
                    rsp.message_client = lock_owner[r.lock_id];
                    rsp.message_lock = r.lock_id;
                end
                PH_WAIT:
                begin
                    lock_waiters[r.lock_id] = lock_waiters[r.lock_id] | client_bit;
                    rsp.reply_status = STATUS_RETRY;
                end
                default:
                begin
                    if (r.client_id == lock_retry_client[r.lock_id])
                    begin
                        // The retried client takes the lock; a revoke follows if others wait.
                        lock_waiters[r.lock_id] = lock_waiters[r.lock_id] & ~client_bit;
                        lock_owner[r.lock_id] = r.client_id;
                        lock_retry_client[r.lock_id] = '0;
                        if (lock_waiters[r.lock_id] == '0)
                        begin
                            lock_state[r.lock_id] = PH_LOCKED;
                        end
                        else
                        begin
                            lock_state[r.lock_id] = PH_WAIT;
                            rsp.message_kind = MSG_REVOKE;
                            rsp.message_client = r.client_id;
                            rsp.message_lock = r.lock_id;
                        end
                    end
                    else
                    begin
                        lock_waiters[r.lock_id] = lock_waiters[r.lock_id] | client_bit;
                        rsp.reply_status = STATUS_RETRY;
                    end
                end
            endcase
        end
        else
        begin
            case (lock_state[r.lock_id])
                PH_LOCKED:
                begin
                    lock_state[r.lock_id] = PH_FREE;
                    lock_owner[r.lock_id] = '0;
                end
                PH_WAIT:
                begin
                    if (lock_waiters[r.lock_id] == '0)
                    begin
                        lock_state[r.lock_id] = PH_FREE;
                        lock_owner[r.lock_id] = '0;
                    end
                    else
                    begin
                        // The lowest-numbered waiter is told to retry and stays queued.
                        for (int c = CLIENTS - 1; c >= 0; c--)
                        begin
                            if (lock_waiters[r.lock_id][c])
                                lowest = CLIENT_W'(c);
                        end
                        lock_state[r.lock_id] = PH_RETRY;
                        lock_retry_client[r.lock_id] = lowest;
                        rsp.message_kind = MSG_RETRY;
                        rsp.message_client = lowest;
                        rsp.message_lock = r.lock_id;
                    end
                end
                default:
                begin
                end
            endcase
        end
        return rsp;
    endfunction

    // Queues one request, marking where the sender must drain and where it must not idle.
    task automatic add_item(logic m, logic [LOCK_W-1:0] l, logic [CLIENT_W-1:0] c);
        pending_item_t item;
        item.req.mode = m;
        item.req.lock_id = l;
        item.req.client_id = c;
        item.hold = !directed_phase && (random_items % 125 == 0);
        item.calm = directed_phase || (random_items >= 200 && random_items < 320);
        pending.push_back(item);
        if (!touched[l])
        begin
            touched[l] = 1'b1;
            touched_locks.push_back(l);
        end
        if (!directed_phase)
            random_items++;
    endtask

    // A contention round on a fresh lock: grant, revoke, retries and re-grants; it may end with clients still queued.
    task automatic run_contention_episode(logic [LOCK_W-1:0] l);
        logic [CLIENTS-1:0] queued;
        logic [CLIENT_W-1:0] c;
        logic [CLIENT_W-1:0] target;
        queued = '0;
        target = '0;
        add_item(MODE_ACQUIRE, l, any_client());
        repeat ($urandom_range(1, 4))
        begin
            c = any_client();
            queued[c] = 1'b1;
            add_item(MODE_ACQUIRE, l, c);
        end
        while (queued != '0)
        begin
            add_item(MODE_RELEASE, l, any_client());
            for (int i = CLIENTS - 1; i >= 0; i--)
            begin
                if (queued[i])
                    target = CLIENT_W'(i);
            end
            c = any_client();
            if ($urandom_range(1) == 1 && c != target)
            begin
                queued[c] = 1'b1;
                add_item(MODE_ACQUIRE, l, c);
            end
            if ($urandom_range(4) == 0)
                add_item(MODE_RELEASE, l, any_client());
            add_item(MODE_ACQUIRE, l, target);
            queued[target] = 1'b0;
            if (queued != '0 && $urandom_range(3) == 0)
                break;
        end
        if ($urandom_range(1) == 1)
            add_item(MODE_RELEASE, l, any_client());
    endtask

    // A single unrelated request, mostly on locks that already carry state.
    task automatic add_noise_item();
        logic [LOCK_W-1:0] l;
        case ($urandom_range(3))
            0: l = any_lock();
            3: l = ($urandom_range(1) == 1) ? TOP_LOCK : '0;
            default: l = touched_locks[$urandom_range(touched_locks.size() - 1)];
        endcase
        add_item(1'($urandom_range(1)), l, any_client());
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        logic [LOCK_W-1:0] fresh;
        bit found;
        for (int i = 0; i < LOCKS; i++)
        begin
            lock_state[i] = PH_FREE;
            lock_owner[i] = '0;
            lock_waiters[i] = '0;
            lock_retry_client[i] = '0;
            touched[i] = 1'b0;
        end

        // Directed: a full revoke and retry chain on the top lock, then the bottom lock.
        add_item(MODE_ACQUIRE, TOP_LOCK, TOP_CLIENT);
        add_item(MODE_ACQUIRE, TOP_LOCK, '0);
        add_item(MODE_ACQUIRE, TOP_LOCK, CLIENT_W'(7));
        add_item(MODE_RELEASE, TOP_LOCK, CLIENT_W'(3));
        add_item(MODE_ACQUIRE, TOP_LOCK, CLIENT_W'(9));
        add_item(MODE_ACQUIRE, TOP_LOCK, '0);
        add_item(MODE_RELEASE, TOP_LOCK, '0);
        add_item(MODE_RELEASE, TOP_LOCK, CLIENT_W'(5));
        add_item(MODE_ACQUIRE, TOP_LOCK, CLIENT_W'(7));
        add_item(MODE_RELEASE, TOP_LOCK, CLIENT_W'(7));
        add_item(MODE_ACQUIRE, TOP_LOCK, CLIENT_W'(9));
        add_item(MODE_RELEASE, TOP_LOCK, CLIENT_W'(9));
        add_item(MODE_RELEASE, TOP_LOCK, CLIENT_W'(9));
        add_item(MODE_ACQUIRE, '0, '0);
        add_item(MODE_RELEASE, '0, '0);
        add_item(MODE_ACQUIRE, '0, TOP_CLIENT);
        add_item(MODE_ACQUIRE, '0, TOP_CLIENT);
        add_item(MODE_RELEASE, '0, TOP_CLIENT);
        add_item(MODE_ACQUIRE, '0, TOP_CLIENT);
        add_item(MODE_ACQUIRE, '0, CLIENT_W'(10));
        add_item(MODE_RELEASE, '0, '0);
        directed_phase = 1'b0;

        // Random: mostly contention rounds on fresh locks, the rest scattered noise.
        while (random_items < RANDOM_ITEMS)
        begin
            found = 1'b0;
            fresh = '0;
            if ($urandom_range(99) < 70)
            begin
                for (int t = 0; t < 64 && !found; t++)
                begin
                    fresh = any_lock();
                    found = !touched[fresh];
                end
            end
            if (found)
                run_contention_episode(fresh);
            else
                add_noise_item();
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || start || accepted_count != received_count)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("[caching_lock_manager_top] OK");
        else
            $display("[caching_lock_manager_top] ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #1000000;
        $display("[caching_lock_manager_top] ERROR");
        $finish;
    end

    // Request driver: records each taken item and presents the next one.
    always @(posedge clk)
    begin
        bit taken;
        bit clear_to_send;
        taken = start && !busy;
        if (rst_n)
        begin
            if (taken)
            begin
                awaited_replies.push_back(serve_request(request));
                void'(pending.pop_front());
                accepted_count <= accepted_count + 1;
            end
            // A presented item stays on the port until it is taken.
            if (!(start && busy))
            begin
                clear_to_send = pending.size() != 0;
                if (clear_to_send && pending[0].hold)
                    clear_to_send = !taken && accepted_count == received_count;
                if (clear_to_send && !pending[0].calm && $urandom_range(99) < 37)
                    clear_to_send = 1'b0;
                if (clear_to_send)
                begin
                    start <= 1'b1;
                    request <= pending[0].req;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each reply with the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            received_count <= received_count + 1;
            if (awaited_replies.size() == 0)
            begin
                $error("reply with no request outstanding: %h", result);
                mismatch_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (result.reply_status !== want.reply_status)
                begin
                    $error("reply_status: expected %0d, got %0d",
                        want.reply_status, result.reply_status);
                    mismatch_count++;
                end
                if (result.message_kind !== want.message_kind)
                begin
                    $error("message_kind: expected %0d, got %0d",
                        want.message_kind, result.message_kind);
                    mismatch_count++;
                end
                if (result.message_client !== want.message_client)
                begin
                    $error("message_client: expected %0d, got %0d",
                        want.message_client, result.message_client);
                    mismatch_count++;
                end
                if (result.message_lock !== want.message_lock)
                begin
                    $error("message_lock: expected %0d, got %0d",
                        want.message_lock, result.message_lock);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
